### sv/assert_macros.svh
// Assertion macros used by the checker file arp_checker.sv.
// Both macros expect a signal named clk in the scope where they are used; ASSERT_CLK also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked at every rising clock edge, during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/arp_pkg.sv
package arp_pkg;

	localparam int ENTRIES = 16;
	localparam int PORTS   = 16;

	localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int PORT_W = 4;
	localparam int KIND_W = 2;
	// Wide enough to hold PORTS itself for the range check.
	localparam int PCMP_W = 9;

	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

	typedef struct packed {
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
	} entry_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              changed;
		logic              full_res;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
	} res_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		entry_t        wdata;
		logic [AW-1:0] raddr;
	} ram_req_t;

endpackage

### sv/arp_cache_table_top.sv
// ARP cache: one request at a time, each scanning all table slots through the RAM read port.
// Steps: scan every slot, take the last read in a drain state, then load the result register.
// The scan reads one slot per cycle; the final step waits while a result waits for m_tready.
// The result register lets the next request start while a result waits for m_tready.
// Reset (arst_n low, asynchronous) clears all valid bits and m_tvalid and idles the controller.
module arp_cache_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Bits from the lowest: ip_addr[31:0], mac_in[79:32], port_in[83:80], zero pad[87:84].
	input  logic [87:0] s_tdata,
	// Bits from the lowest: kind[1:0].
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Bits from the lowest: mac_out[47:0], port_out[51:48], zero pad[55:52].
	output logic [55:0] m_tdata,
	// Bits from the lowest: hit[0], changed[1], full_res[2].
	output logic [2:0]  m_tuser
);

	arp_pkg::req_t      in_req;
	arp_pkg::res_t      res;
	arp_pkg::ram_req_t  ram_req;
	arp_pkg::entry_t    ram_rdata;
	logic               res_load;
	logic               out_free;
	logic               m_tvalid_q;
	arp_pkg::res_t      res_q;

	assign in_req.kind = s_tuser;
	assign in_req.ip   = s_tdata[31:0];
	assign in_req.mac  = s_tdata[79:32];
	assign in_req.port = s_tdata[83:80];

	assign out_free = !m_tvalid_q || m_tready;

	arp_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	arp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (in_req),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, res_q.port, res_q.mac};
	assign m_tuser  = {res_q.full_res, res_q.changed, res_q.hit};

endmodule

### sv/arp_ram.sv
module arp_ram (
	input  logic               clk,
	input  arp_pkg::ram_req_t  req,
	output arp_pkg::entry_t    rdata
);

	arp_pkg::entry_t mem [arp_pkg::ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

### sv/arp_ctrl.sv
module arp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  arp_pkg::req_t      in_req,
	input  logic               out_free,
	output logic               res_load,
	output arp_pkg::res_t      res,
	output arp_pkg::ram_req_t  ram_req,
	input  arp_pkg::entry_t    ram_rdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [arp_pkg::AW-1:0] LAST_IDX = arp_pkg::AW'(arp_pkg::ENTRIES - 1);

	logic [1:0]                    state_q;
	arp_pkg::req_t                 req_q;
	logic [arp_pkg::AW-1:0]        rd_addr_q;
	logic                          rd_vld_s1;
	logic [arp_pkg::AW-1:0]        rd_idx_s1;
	logic [arp_pkg::ENTRIES-1:0]   valid_q;
	logic                          match_q;
	logic [arp_pkg::AW-1:0]        match_idx_q;
	logic [arp_pkg::MAC_W-1:0]     old_mac_q;
	logic [arp_pkg::PORT_W-1:0]    old_port_q;
	logic                          free_q;
	logic [arp_pkg::AW-1:0]        free_idx_q;

	logic                          in_acc;
	logic                          fin_go;
	logic                          is_upd;
	logic                          is_del;
	logic                          port_ok;
	logic                          diff;
	logic                          wr_en;
	logic [arp_pkg::AW-1:0]        wr_idx;
	logic                          set_v;
	logic                          clr_v;
	logic                          changed;
	logic                          full;
	logic                          rd_match;
	logic                          rd_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign fin_go   = (state_q == ST_FIN) && out_free;

	// A slot read back this cycle; its valid bit is current because the table
	// is only written in the final step of a request.
	assign rd_match = rd_vld_s1 && valid_q[rd_idx_s1] && (ram_rdata.ip == req_q.ip);
	assign rd_free  = rd_vld_s1 && !valid_q[rd_idx_s1];

	always_comb begin
		is_upd  = (req_q.kind == arp_pkg::KIND_UPDATE);
		is_del  = (req_q.kind == arp_pkg::KIND_DELETE);
		port_ok = arp_pkg::PCMP_W'(req_q.port) < arp_pkg::PCMP_W'(arp_pkg::PORTS);
		diff    = (old_mac_q != req_q.mac) || (old_port_q != req_q.port);
		wr_en   = 1'b0;
		wr_idx  = match_idx_q;
		set_v   = 1'b0;
		clr_v   = 1'b0;
		changed = 1'b0;
		full    = 1'b0;
		if (is_upd && port_ok) begin
			if (match_q) begin
				if (diff) begin
					wr_en   = 1'b1;
					changed = 1'b1;
				end
			end else if (free_q) begin
				wr_en   = 1'b1;
				wr_idx  = free_idx_q;
				set_v   = 1'b1;
				changed = 1'b1;
			end else begin
				full = 1'b1;
			end
		end
		if (is_del && match_q) begin
			clr_v   = 1'b1;
			changed = 1'b1;
		end
	end

	assign res_load      = fin_go;
	assign res.hit       = match_q;
	assign res.changed   = changed;
	assign res.full_res  = full;
	assign res.mac       = match_q ? old_mac_q : '0;
	assign res.port      = match_q ? old_port_q : '0;

	assign ram_req.we          = fin_go && wr_en;
	assign ram_req.waddr       = wr_idx;
	assign ram_req.wdata.ip    = req_q.ip;
	assign ram_req.wdata.mac   = req_q.mac;
	assign ram_req.wdata.port  = req_q.port;
	assign ram_req.raddr       = rd_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_addr_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			valid_q   <= '0;
			match_q   <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			rd_idx_s1 <= rd_addr_q;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q   <= ST_SCAN;
						rd_addr_q <= '0;
						match_q   <= 1'b0;
						free_q    <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (rd_addr_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (set_v) begin
							valid_q[wr_idx] <= 1'b1;
						end
						if (clr_v) begin
							valid_q[match_idx_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// The lowest matching slot and the lowest free slot win.
			if (rd_match && !match_q) begin
				match_q <= 1'b1;
			end
			if (rd_free && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= in_req;
		end
		if (rd_match && !match_q) begin
			match_idx_q <= rd_idx_s1;
			old_mac_q   <= ram_rdata.mac;
			old_port_q  <= ram_rdata.port;
		end
		if (rd_free && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

endmodule

### sv/arp_checker.sv
`include "assert_macros.svh"

module arp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [87:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [2:0]  m_tuser
);

	logic [1:0]  pend_q;
	logic        in_acc;
	logic        out_acc;
	logic        out_stall;
	logic [58:0] out_word;

	assign in_acc    = s_tvalid && s_tready;
	assign out_acc   = m_tvalid && m_tready;
	assign out_stall = m_tvalid && !m_tready;
	assign out_word  = {m_tuser, m_tdata};

	// Requests taken whose result word has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	`ASSERT_CLK(a_out_hold, out_stall |=> m_tvalid && $stable(out_word), "result changed in stall")
	`ASSERT_CLK(a_out_owed, m_tvalid |-> pend_q != 2'd0, "result word without a pending request")
	`ASSERT_CLK(a_one_at_a_time, in_acc |=> !s_tready, "request taken while another is busy")
	`ASSERT_CLK(a_miss_zero, m_tvalid && !m_tuser[0] |-> m_tdata == 56'd0, "miss with nonzero data")
	`ASSERT_CLK(a_full_alone, m_tvalid && m_tuser[2] |-> m_tuser[1:0] == 2'b00, "full with hit or change")

endmodule

bind arp_cache_table_top arp_checker u_arp_checker (.*);
